// ----- src/dbf_pkg.sv -----
// dbf_pkg: shared types and constants for the distance blend factor block.
// No dependencies; imported by dbf_div and distance_blend_factor.
package dbf_pkg;

  localparam int DBF_DIST_WIDTH = 24;
  localparam int DBF_FRAC_WIDTH = 16;
  localparam int INFL_W         = 16;
  localparam int CODE_W         = 8;
  localparam int CFG_ADDR_W     = 3;

  // register indexes of the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_REFERENCE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_NEAR      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FAR       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_OVERRIDE  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MESH      = 3'd4;

  typedef enum logic [1:0] {
    STATE_NONE   = 2'd0,
    STATE_NEAR   = 2'd1,
    STATE_FAR    = 2'd2,
    STATE_CUSTOM = 2'd3
  } dbf_state_t;

  // per-item data that rides along the divider
  typedef struct packed {
    logic signed [INFL_W-1:0] infl;
    dbf_state_t               state;
    logic                     ovr;
  } dbf_side_t;

endpackage

// ----- src/distance_blend_factor.sv -----
// distance_blend_factor: top level, decode, smoothstep, influence scaling and output skid.
// Depends on dbf_pkg and dbf_div.
//
// Accepts one request per cycle while in_stall is low and returns one result per
// request, in order. A result reaches the output register through one decode stage,
// FRAC_WIDTH+1 divider stages that each resolve one quotient bit, two stages for t^2
// and t^3, one for the smoothstep combine, one for the influence product and one for
// the code quantization. The restoring divider makes up most of those stages; while
// in_stall is low, throughput stays at one request per cycle. A skid register behind
// the output register takes the result that arrives while the output is held, so the
// pipeline stops only once the skid register is full; in_stall follows its occupancy.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata and is meant to change
// only while the block is empty.
module distance_blend_factor #(
  parameter int DIST_WIDTH = dbf_pkg::DBF_DIST_WIDTH,
  parameter int FRAC_WIDTH = dbf_pkg::DBF_FRAC_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [dbf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [DIST_WIDTH-1:0]             cfg_wdata,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [DIST_WIDTH-1:0]             in_current_distance,
  input  logic                              in_objects_present,
  input  logic signed [dbf_pkg::INFL_W-1:0] in_influence,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dbf_pkg::CODE_W-1:0]        out_blend_code,
  output logic [1:0]                        out_blend_state
);
  import dbf_pkg::*;

  localparam int DW   = DIST_WIDTH;
  localparam int FW   = FRAC_WIDTH;
  localparam int TW   = FW + 1;          // fraction with one integer bit
  localparam int PW   = FW + INFL_W;     // fraction times positive influence
  localparam logic [TW-1:0] ONE_FRAC = TW'(1) << FW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DW-1:0] ref_r, near_r, far_r;
  logic          ovr_r, mesh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r  <= '0;
      near_r <= '0;
      far_r  <= '0;
      ovr_r  <= 1'b0;
      mesh_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_REFERENCE: ref_r  <= cfg_wdata;
        REG_NEAR:      near_r <= cfg_wdata;
        REG_FAR:       far_r  <= cfg_wdata;
        REG_OVERRIDE:  ovr_r  <= cfg_wdata[0];
        REG_MESH:      mesh_r <= cfg_wdata[0];
        default: ;     // unknown index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: the whole pipeline advances unless the skid register is full.
  // ---------------------------------------------------------------------------
  logic      skid_v_r;
  logic      en;
  logic      in_acc;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;
  assign in_acc   = in_valid && en;

  // ---------------------------------------------------------------------------
  // Decode stage: pick the side, form numerator and denominator.
  // Every branch that sets no numerator and denominator divides 0 by 1.
  // ---------------------------------------------------------------------------
  logic [DW-1:0] num_nxt, den_nxt, num_r, den_r;
  dbf_side_t     side_nxt, side_r;
  logic          dec_v_r;
  logic [DW-1:0] lo, hi;

  always_comb begin
    num_nxt        = '0;
    den_nxt        = DW'(1);
    side_nxt.infl  = in_influence;
    side_nxt.state = STATE_NONE;
    side_nxt.ovr   = 1'b0;
    lo = (in_current_distance > near_r) ? in_current_distance : near_r;
    hi = (in_current_distance < far_r)  ? in_current_distance : far_r;
    priority if (!mesh_r) begin
      // invalid setup: fraction stays zero
    end else if (ovr_r) begin
      side_nxt.ovr   = 1'b1;
      side_nxt.state = STATE_CUSTOM;
    end else if (in_objects_present && ref_r != '0 && (near_r <= ref_r || far_r >= ref_r)) begin
      priority if (in_current_distance < ref_r) begin
        if (near_r < ref_r) begin
          side_nxt.state = STATE_NEAR;
          num_nxt        = ref_r - lo;
          den_nxt        = ref_r - near_r;
        end
      end else if (in_current_distance > ref_r) begin
        if (far_r > ref_r) begin
          side_nxt.state = STATE_FAR;
          num_nxt        = hi - ref_r;
          den_nxt        = far_r - ref_r;
        end
      end else begin
        // distance at the reference: zero blend
      end
    end else begin
      // invalid setup
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_v_r <= 1'b0;
    end else if (en) begin
      dec_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      num_r  <= num_nxt;
      den_r  <= den_nxt;
      side_r <= side_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Linear position t = num * 2^F / den
  // ---------------------------------------------------------------------------
  logic          div_v;
  logic [FW:0]   div_q;
  dbf_side_t     div_side;

  dbf_div #(
    .DW (DW),
    .FW (FW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (dec_v_r),
    .in_num   (num_r),
    .in_den   (den_r),
    .in_side  (side_r),
    .out_v    (div_v),
    .out_q    (div_q),
    .out_side (div_side)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: t^2 >> F.  Stage 2: t^3 >> F.
  // ---------------------------------------------------------------------------
  logic [2*TW-1:0] sq_prod, cu_prod;
  logic [TW-1:0]   t1_r, t2a_r, t2b_r, t3_r;
  dbf_side_t       s1_side_r, s2_side_r, s3_side_r;
  logic            s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;

  assign sq_prod = div_q * div_q;
  assign cu_prod = t2a_r * t1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r      <= div_q;
      t2a_r     <= sq_prod[2*FW:FW];
      s1_side_r <= div_side;
      t2b_r     <= t2a_r;
      t3_r      <= cu_prod[2*FW:FW];
      s2_side_r <= s1_side_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: s = 3*t2 - 2*t3, clamped to 0..1; override forces one.
  // ---------------------------------------------------------------------------
  logic [TW+1:0] three_t2, two_t3, s_diff;
  logic [TW-1:0] frac_nxt, frac_r;

  always_comb begin
    three_t2 = {2'b00, t2b_r} + {1'b0, t2b_r, 1'b0};
    two_t3   = {1'b0, t3_r, 1'b0};
    s_diff   = three_t2 - two_t3;
    priority if (s2_side_r.ovr) begin
      frac_nxt = ONE_FRAC;
    end else if (three_t2 < two_t3) begin
      frac_nxt = '0;
    end else if (s_diff > {2'b00, ONE_FRAC}) begin
      frac_nxt = ONE_FRAC;
    end else begin
      frac_nxt = s_diff[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frac_r    <= frac_nxt;
      s3_side_r <= s2_side_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: p = frac * influence; non-positive influence or zero fraction gives 0.
  // ---------------------------------------------------------------------------
  logic [PW-1:0] p_nxt, p_r;
  logic          zero_nxt, zero_r;
  dbf_state_t    s4_state_r;

  assign p_nxt    = frac_r * s3_side_r.infl[INFL_W-2:0];
  assign zero_nxt = s3_side_r.infl[INFL_W-1] || (s3_side_r.infl == '0) || (frac_r == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r        <= p_nxt;
      zero_r     <= zero_nxt;
      s4_state_r <= s3_side_r.state;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: code = p * 255 >> (F+8), or 255 once p reaches one.
  // ---------------------------------------------------------------------------
  logic [PW-1:0]     p255;
  logic              sat;
  logic [CODE_W-1:0] code_nxt, code_r;
  dbf_state_t        state_nxt, state5_r;

  always_comb begin
    sat  = |p_r[PW-1:FW+8];
    p255 = {p_r[FW+7:0], 8'h00} - {8'h00, p_r[FW+7:0]};
    priority if (zero_r) begin
      code_nxt = '0;
    end else if (sat) begin
      code_nxt = '1;
    end else begin
      code_nxt = p255[PW-1:FW+8];
    end
    state_nxt = (code_nxt == '0) ? STATE_NONE : s4_state_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code_r   <= code_nxt;
      state5_r <= state_nxt;
    end
  end

  // valid bits of stages 1..5
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= div_v;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and skid register.
  // Hold the output while stalled; park the next result in the skid register.
  // ---------------------------------------------------------------------------
  logic              out_v_r;
  logic [CODE_W-1:0] out_code_r, skid_code_r;
  dbf_state_t        out_state_r, skid_state_r;
  logic              out_free;
  logic              tail_v;

  assign out_free = !out_v_r || !out_stall;
  assign tail_v   = en && s5_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r  <= skid_v_r || tail_v;
      skid_v_r <= 1'b0;
    end else if (tail_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_v_r) begin
        out_code_r  <= skid_code_r;
        out_state_r <= skid_state_r;
      end else begin
        out_code_r  <= code_r;
        out_state_r <= state5_r;
      end
    end else if (tail_v) begin
      skid_code_r  <= code_r;
      skid_state_r <= state5_r;
    end
  end

  assign out_valid       = out_v_r;
  assign out_blend_code  = out_code_r;
  assign out_blend_state = out_state_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a zero code always reports state none
  a_zero_code_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_code_r == '0) |-> (out_state_r == STATE_NONE))
    else $error("zero blend code with a state other than none");

  // the skid register only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register full while output register empty");

  // the skid register fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && out_stall))
    else $error("skid register filled without an output stall");

endmodule

// ----- src/dbf_div.sv -----
// dbf_div: pipelined restoring divider, one quotient bit per stage.
// Depends on dbf_pkg for the sideband struct.
module dbf_div #(
  parameter int DW = 24,
  parameter int FW = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_v,
  input  logic [DW-1:0]       in_num,
  input  logic [DW-1:0]       in_den,
  input  dbf_pkg::dbf_side_t  in_side,
  output logic                out_v,
  output logic [FW:0]         out_q,
  output dbf_pkg::dbf_side_t  out_side
);
  import dbf_pkg::*;

  localparam int NST = FW + 1;

  // numerator never exceeds the denominator, so the quotient fits FW+1 bits
  logic [NST-1:0]  v_r;
  logic [DW:0]     rem_r  [NST];
  logic [DW-1:0]   den_r  [NST];
  logic [FW:0]     q_r    [NST];
  dbf_side_t       side_r [NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [DW:0]   rin;
    logic [DW-1:0] dn;
    logic [FW:0]   qin;
    dbf_side_t     sin;
    logic          vin;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW:0]   rem_nxt;
    logic [FW:0]   q_nxt;

    if (k == 0) begin : g_first
      assign rin = {1'b0, in_num};
      assign dn  = in_den;
      assign qin = '0;
      assign sin = in_side;
      assign vin = in_v;
    end else begin : g_rest
      assign rin = {rem_r[k-1][DW-1:0], 1'b0};
      assign dn  = den_r[k-1];
      assign qin = q_r[k-1];
      assign sin = side_r[k-1];
      assign vin = v_r[k-1];
    end

    always_comb begin
      diff    = rin - {1'b0, dn};
      ge      = rin >= {1'b0, dn};
      rem_nxt = ge ? diff : rin;
      q_nxt   = qin;
      q_nxt[FW-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= dn;
        q_r[k]    <= q_nxt;
        side_r[k] <= sin;
      end
    end
  end

  assign out_v    = v_r[NST-1];
  assign out_q    = q_r[NST-1];
  assign out_side = side_r[NST-1];

endmodule

// ----- tb/distance_blend_factor_tb.sv -----
// Self-checking testbench for distance_blend_factor: random-paced requests, a bit-exact
// blend predictor and an in-order result check. Depends on dbf_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;
  import dbf_pkg::*;

  localparam int DW = DBF_DIST_WIDTH;
  localparam int FW = DBF_FRAC_WIDTH;
  // Results sit in the decode, divider, arithmetic and output registers plus the skid entry.
  // Give it some margin before touching registers or ending the run.
  localparam int DRAIN_CYCLES = FW + 8 + 12;
  localparam logic [63:0] FRAC_ONE = 64'd1 << FW;
  localparam logic [63:0] PROD_ONE = 64'd1 << (FW + 8);
  localparam logic [63:0] CODE_SCALE = 64'd255;
  localparam logic [DW-1:0] DIST_MAX = '1;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_FIRST = REG_MESH + 1'b1;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LAST = '1;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int SWEEP_PHASES = 10;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    dbf_state_t        state;
  } blend_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_ADDR_W-1:0]    cfg_addr;
  logic [DW-1:0]            cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  logic [DW-1:0]            in_current_distance;
  logic                     in_objects_present;
  logic signed [INFL_W-1:0] in_influence;
  logic                     out_valid;
  logic                     out_stall;
  logic [CODE_W-1:0]        out_blend_code;
  logic [1:0]               out_blend_state;

  // Shadow copy of the configuration registers, updated on every write.
  logic [DW-1:0] reg_base;
  logic [DW-1:0] reg_near;
  logic [DW-1:0] reg_far;
  logic          reg_override;
  logic          reg_mesh;

  blend_result_t blend_expect_q[$];
  int            mismatch_count;
  int            stall_left;
  bit            src_idle_en;
  bit            sink_idle_en;

  distance_blend_factor DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_addr            (cfg_addr),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_current_distance (in_current_distance),
    .in_objects_present  (in_objects_present),
    .in_influence        (in_influence),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_blend_code      (out_blend_code),
    .out_blend_state     (out_blend_state)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Work out the blend code and state for one request under the current registers.
  // Everything is widened to 64 bits; the shifted numerator needs DIST_WIDTH+FRAC_WIDTH.
  function automatic blend_result_t predict_blend(logic [DW-1:0] cur_dist, logic objs,
                                                  logic signed [INFL_W-1:0] infl);
    logic [63:0] base_w, near_w, far_w, dist_w;
    logic [63:0] t, t2, t3, s, frac, p, span, edge_d;
    logic        usable;
    blend_result_t r;
    base_w  = 64'(reg_base);
    near_w  = 64'(reg_near);
    far_w   = 64'(reg_far);
    dist_w  = 64'(cur_dist);
    frac    = '0;
    t       = '0;
    r.state = STATE_NONE;
    r.code  = '0;

    // Setup check: mesh gates everything, override bypasses the distance checks.
    if (!reg_mesh)
      usable = 1'b0;
    else if (reg_override)
      usable = 1'b1;
    else
      usable = objs && base_w != 0 && (near_w <= base_w || far_w >= base_w);

    if (usable) begin
      if (reg_override) begin
        frac    = FRAC_ONE;
        r.state = STATE_CUSTOM;
      end else begin
        // Map toward the limit on the side the distance falls; clamp at the limit.
        if (dist_w < base_w) begin
          if (near_w < base_w) begin
            span    = base_w - near_w;
            edge_d  = (dist_w > near_w) ? dist_w : near_w;
            r.state = STATE_NEAR;
            t       = ((base_w - edge_d) << FW) / span;
          end
        end else if (dist_w > base_w) begin
          if (far_w > base_w) begin
            span    = far_w - base_w;
            edge_d  = (dist_w < far_w) ? dist_w : far_w;
            r.state = STATE_FAR;
            t       = ((edge_d - base_w) << FW) / span;
          end
        end
        if (t > FRAC_ONE)
          t = FRAC_ONE;
        // Smoothstep 3t^2 - 2t^3 with truncation after each product.
        t2 = (t * t) >> FW;
        t3 = (t2 * t) >> FW;
        if (3 * t2 < 2 * t3)
          s = '0;
        else
          s = 3 * t2 - 2 * t3;
        if (s > FRAC_ONE)
          s = FRAC_ONE;
        frac = s;
      end
    end

    if (infl <= 0 || frac == 0) begin
      r.code = '0;
    end else begin
      p = frac * 64'(infl);
      if (p >= PROD_ONE)
        r.code = CODE_SCALE[CODE_W-1:0];
      else
        r.code = CODE_W'((p * CODE_SCALE) >> (FW + 8));
    end
    // A zero code never reports a side.
    if (r.code == 0)
      r.state = STATE_NONE;
    return r;
  endfunction

  // Source gap: mostly back-to-back, some short holes, a few long ones.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (!src_idle_en || roll < 55)
      return 0;
    if (roll < 92)
      return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Sink pacing: random stall bursts, mostly short, a few long.
  initial begin
    out_stall  <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (sink_idle_en && $urandom_range(99) < 18) begin
        out_stall  <= 1'b1;
        stall_left = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(2, 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest pending prediction.
  always @(posedge clk) begin : result_check
    blend_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (blend_expect_q.size() == 0) begin
        $display("%0t: result with nothing pending, actual code %0d state %0d",
                 $time, out_blend_code, out_blend_state);
        mismatch_count++;
      end else begin
        want = blend_expect_q.pop_front();
        if (out_blend_code !== want.code) begin
          $display("%0t: blend_code expected %0d actual %0d",
                   $time, want.code, out_blend_code);
          mismatch_count++;
        end
        if (out_blend_state !== want.state) begin
          $display("%0t: blend_state expected %0d actual %0d",
                   $time, want.state, out_blend_state);
          mismatch_count++;
        end
      end
    end
  end

  // Offer one request after a random gap and hold it until taken; predict on accept.
  // Valid stays high on return so a following request can go out back to back.
  task automatic send_request(logic [DW-1:0] cur_dist, logic objs,
                              logic signed [INFL_W-1:0] infl);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_current_distance <= cur_dist;
    in_objects_present  <= objs;
    in_influence        <= infl;
    do @(posedge clk); while (in_stall);
    blend_expect_q.push_back(predict_blend(cur_dist, objs, infl));
  endtask

  // Drop valid, wait for every pending result, then let the pipeline empty.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (blend_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; the caller lowers cfg_we after its last write.
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_REFERENCE: reg_base     = data;
      REG_NEAR:      reg_near     = data;
      REG_FAR:       reg_far      = data;
      REG_OVERRIDE:  reg_override = data[0];
      REG_MESH:      reg_mesh     = data[0];
      default: ;
    endcase
  endtask

  // Rewrite all registers while the block is empty. Flag registers get random
  // upper bits so only bit 0 matters.
  task automatic apply_setup(logic [DW-1:0] base_v, logic [DW-1:0] near_v,
                             logic [DW-1:0] far_v, logic ovr, logic mesh);
    logic [DW-1:0] noise;
    noise = DW'($urandom);
    wait_drained();
    write_reg(REG_REFERENCE, base_v);
    write_reg(REG_NEAR, near_v);
    write_reg(REG_FAR, far_v);
    write_reg(REG_OVERRIDE, {noise[DW-1:1], ovr});
    write_reg(REG_MESH, {~noise[DW-1:1], mesh});
    cfg_we <= 1'b0;
  endtask

  // Out of reset the mesh flag is clear, so every request must come back as none.
  task automatic test_reset_state();
    send_request(24'h000100, 1'b1, 16'sd256);
    send_request(DIST_MAX, 1'b1, 16'sd32767);
  endtask

  // Hand-picked requests for each special case of the setup and the mapping.
  task automatic test_directed_cases();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    // Normal setup: base 256.0, near 128.0, far 512.0.
    apply_setup(24'h010000, 24'h008000, 24'h020000, 1'b0, 1'b1);
    send_request(24'h010000, 1'b1, 16'sd256);        // distance on the base
    send_request('0, 1'b1, 16'sd256);                // past the near limit
    send_request(DIST_MAX, 1'b1, 16'sd256);          // past the far limit
    send_request(24'h00C000, 1'b1, 16'sd256);        // halfway to near
    send_request(24'h018000, 1'b1, 16'sd32767);      // halfway to far, full influence
    send_request('0, 1'b1, 16'sd0);                  // zero influence
    send_request('0, 1'b1, -16'sd32768);             // most negative influence
    send_request('0, 1'b1, 16'sd1);                  // code truncates to zero
    send_request('0, 1'b0, 16'sd256);                // objects missing
    // Near above base and far below it: setup invalid.
    apply_setup(24'h010000, 24'h020000, 24'h008000, 1'b0, 1'b1);
    send_request('0, 1'b1, 16'sd256);
    send_request(DIST_MAX, 1'b1, 16'sd256);
    // Near limit not below base: near side gives nothing, far side still works.
    apply_setup(24'h010000, 24'h010000, 24'h020000, 1'b0, 1'b1);
    send_request(24'h004000, 1'b1, 16'sd256);
    send_request(24'h01C000, 1'b1, 16'sd300);
    // Far limit equal to base: far side gives nothing.
    apply_setup(24'h010000, 24'h008000, 24'h010000, 1'b0, 1'b1);
    send_request(24'h030000, 1'b1, 16'sd256);
    // Zero base distance: setup invalid.
    apply_setup('0, '0, 24'h020000, 1'b0, 1'b1);
    send_request(24'h001000, 1'b1, 16'sd256);
    // Override: custom state regardless of objects and distances.
    apply_setup('0, DIST_MAX, '0, 1'b1, 1'b1);
    send_request(24'h123456, 1'b0, 16'sd256);
    send_request(24'h123456, 1'b1, 16'sd128);
    send_request(24'h123456, 1'b1, -16'sd1);
    // Override without a mesh is still invalid.
    apply_setup('0, '0, '0, 1'b1, 1'b0);
    send_request(24'h000200, 1'b1, 16'sd256);
  endtask

  // Writes to unused indexes must leave the real registers alone.
  task automatic test_spare_registers();
    apply_setup(24'h400000, 24'h100000, 24'hA00000, 1'b0, 1'b1);
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
      write_reg(CFG_ADDR_W'(i), DW'($urandom));
    cfg_we <= 1'b0;
    send_request(24'h200000, 1'b1, 16'sd256);
    send_request(24'h700000, 1'b1, 16'sd256);
  endtask

  // One random request shaped around the current limits so both sides, the
  // base point and the saturation regions all see plenty of traffic.
  task automatic send_random_request();
    logic [DW-1:0]            cur_dist, lo_d, hi_d;
    logic signed [INFL_W-1:0] infl;
    logic                     objs;
    int                       roll;
    lo_d = (reg_near < reg_base) ? reg_near : reg_base;
    hi_d = (reg_far > reg_base) ? reg_far : reg_base;
    roll = $urandom_range(99);
    if (roll < 8)
      cur_dist = reg_base;
    else if (roll < 20)
      case ($urandom_range(3))
        0: cur_dist = reg_near;
        1: cur_dist = reg_far;
        2: cur_dist = reg_base - 1'b1;
        default: cur_dist = reg_base + 1'b1;
      endcase
    else if (roll < 75)
      cur_dist = DW'($urandom_range(hi_d, lo_d));
    else if (roll < 92)
      cur_dist = DW'($urandom);
    else
      cur_dist = $urandom_range(1) ? DIST_MAX : '0;

    roll = $urandom_range(99);
    if (roll < 55)
      infl = INFL_W'($urandom_range(600, 1));
    else if (roll < 65)
      infl = INFL_W'($urandom_range(257, 255));
    else if (roll < 78)
      infl = INFL_W'(-$urandom_range(32768, 1));
    else if (roll < 86)
      infl = '0;
    else
      infl = INFL_W'($urandom);

    objs = ($urandom_range(9) != 0);
    send_request(cur_dist, objs, infl);
  endtask

  // Random traffic over a series of register settings, extremes among them.
  task automatic test_random_sweep();
    logic [DW-1:0] base_v, near_v, far_v;
    logic          ovr, mesh;
    for (int phase = 0; phase < SWEEP_PHASES; phase++) begin
      ovr  = 1'b0;
      mesh = 1'b1;
      case (phase)
        3: begin  // one-step spans on both sides
          base_v = DW'($urandom_range(DIST_MAX - 1, 2));
          near_v = base_v - 1'b1;
          far_v  = base_v + 1'b1;
        end
        4: begin  // base at the top, far side collapses
          base_v = DIST_MAX;
          near_v = '0;
          far_v  = DIST_MAX;
        end
        5: begin  // base at the bottom, widest far span
          base_v = DW'(1);
          near_v = '0;
          far_v  = DIST_MAX;
        end
        6: begin  // near side blocked
          base_v = DW'($urandom_range(24'hC00000, 24'h100000));
          near_v = DW'($urandom_range(DIST_MAX, base_v));
          far_v  = DW'($urandom_range(DIST_MAX, base_v + 1));
        end
        7: begin  // far side blocked
          base_v = DW'($urandom_range(24'hC00000, 24'h100000));
          near_v = DW'($urandom_range(base_v - 1, 0));
          far_v  = DW'($urandom_range(base_v, 0));
        end
        8: begin  // override with arbitrary distances
          base_v = DW'($urandom);
          near_v = DW'($urandom);
          far_v  = DW'($urandom);
          ovr    = 1'b1;
        end
        9: begin  // anything goes
          base_v = DW'($urandom);
          near_v = DW'($urandom);
          far_v  = DW'($urandom);
          ovr    = $urandom_range(1);
          mesh   = ($urandom_range(3) != 0);
        end
        default: begin  // ordinary setup, limits on either side of the base
          base_v = DW'($urandom_range(24'hE00000, 24'h100000));
          near_v = DW'($urandom_range(base_v - 1, 0));
          far_v  = DW'($urandom_range(DIST_MAX, base_v + 1));
        end
      endcase
      apply_setup(base_v, near_v, far_v, ovr, mesh);
      // Leave some phases free of gaps on one side or the other.
      src_idle_en  = (phase % 4 != 3);
      sink_idle_en = (phase % 5 != 4);
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_random_request();
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_addr            <= REG_REFERENCE;
    cfg_wdata           <= '0;
    in_valid            <= 1'b0;
    in_current_distance <= '0;
    in_objects_present  <= 1'b0;
    in_influence        <= '0;
    reg_base            = '0;
    reg_near            = '0;
    reg_far             = '0;
    reg_override        = 1'b0;
    reg_mesh            = 1'b0;
    mismatch_count      = 0;
    src_idle_en         = 1'b0;
    sink_idle_en        = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_directed_cases();
    test_spare_registers();
    test_random_sweep();
    wait_drained();

    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
